// ===== hdl/pwrd_pkg.sv =====
package pwrd_pkg;

  // Fixed field widths of the configuration registers and result fields.
  localparam int SHORT_W    = 12;
  localparam int LONG_W     = 13;
  localparam int TOL_W      = 12;
  localparam int TBITS_W    = 6;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_CODE_W = 32;
  localparam int BITCNT_W   = 6;

  // Working width for duration compares; covers 32-bit durations and 36x products.
  localparam int ABS_W = 34;

  localparam int DEF_CODE_WIDTH     = 32;
  localparam int DEF_DURATION_WIDTH = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BITS  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [SHORT_W-1:0] RST_SHORT_PERIOD = 12'd400;
  localparam logic [LONG_W-1:0]  RST_LONG_PERIOD  = 13'd800;
  localparam logic [TOL_W-1:0]   RST_TOLERANCE    = 12'd200;
  localparam logic [TBITS_W-1:0] RST_TARGET_BITS  = 6'd12;

  // Multipliers applied to the short period and tolerance.
  localparam logic [ABS_W-1:0] GAP_MULT  = 34'd36;
  localparam logic [ABS_W-1:0] END_MULT  = 34'd10;
  localparam logic [ABS_W-1:0] LONG_MULT = 34'd2;

  localparam logic [BITCNT_W-1:0] BITCNT_MAX = '1;

  typedef enum logic [1:0] {
    PH_WAIT_GAP  = 2'd0,
    PH_START_BIT = 2'd1,
    PH_LOW_HALF  = 2'd2,
    PH_HIGH_HALF = 2'd3
  } phase_t;

  function automatic logic [ABS_W-1:0] abs_diff(input logic [ABS_W-1:0] a,
                                                input logic [ABS_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== hdl/pulse_width_remote_decoder.sv =====
// Pulse-width remote decoder.
//
// Input channel (in_valid / in_ready): one beat is either a pulse (in_kind 0)
// carrying a line level and a duration in microseconds, or a clear command
// (in_kind 1) that returns all decoding state to its reset value.
// Result channel (out_valid / out_ready): exactly one result beat per input
// beat, in order: a confirmation strobe, the last confirmed code, the sticky
// seen-valid flag and the decoder phase after that beat.
// Configuration port (cfg_we / cfg_index / cfg_wdata): single-cycle writes to
// the short period, long period, tolerance and target bit count; write it
// only while no beat is in flight.
//
// A beat accepted into the input register is decoded into the result register
// once that register is empty or being drained, and out_valid is driven from
// the result register, so every result is registered before it can be taken.
// Throughput is one beat per cycle while the receiver does not stall, set by
// the single decode step between those two registers.
// When the receiver stalls, the input register still takes one more beat
// while the result register holds, so in_ready drops only with both full.
// Reset (synchronous, active low) empties both stages, clears the decoder
// state and loads the configuration registers with their default values.
module pulse_width_remote_decoder #(
  parameter int CODE_WIDTH     = pwrd_pkg::DEF_CODE_WIDTH,
  parameter int DURATION_WIDTH = pwrd_pkg::DEF_DURATION_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic                               in_level,
  input  logic [DURATION_WIDTH-1:0]          in_pulse_length,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_code_confirmed,
  output logic [pwrd_pkg::OUT_CODE_W-1:0]    out_confirmed_code,
  output logic                               out_seen_valid,
  output logic [1:0]                         out_phase,
  // Configuration port.
  input  logic                               cfg_we,
  input  logic [pwrd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pwrd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int AW = pwrd_pkg::ABS_W;

  // Configuration registers.
  logic [pwrd_pkg::SHORT_W-1:0] short_period_r;
  logic [pwrd_pkg::LONG_W-1:0]  long_period_r;
  logic [pwrd_pkg::TOL_W-1:0]   tolerance_r;
  logic [pwrd_pkg::TBITS_W-1:0] target_bits_r;

  // Input register stage.
  logic                      in_valid_r;
  logic                      in_kind_r;
  logic                      in_level_r;
  logic [DURATION_WIDTH-1:0] in_len_r;

  // Decoder state.
  pwrd_pkg::phase_t           phase_r, phase_nxt;
  logic [CODE_WIDTH-1:0]      shift_code_r, shift_code_nxt;
  logic [pwrd_pkg::BITCNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [DURATION_WIDTH-1:0]  held_low_r, held_low_nxt;
  logic [CODE_WIDTH-1:0]      prev_code_r, prev_code_nxt;
  logic [CODE_WIDTH-1:0]      final_code_r, final_code_nxt;
  logic                       valid_flag_r, valid_flag_nxt;
  logic                       confirmed_nxt;

  // Result register stage.
  logic                              out_valid_r;
  logic                              out_confirmed_r;
  logic [pwrd_pkg::OUT_CODE_W-1:0]   out_code_r;
  logic                              out_seen_r;
  logic [1:0]                        out_phase_r;
  logic [pwrd_pkg::OUT_CODE_W-1:0]   final_code_out;

  logic advance;
  logic step;

  // The result register moves when it is empty or being drained.
  assign advance  = !out_valid_r || out_ready;
  assign step     = advance && in_valid_r;
  assign in_ready = !in_valid_r || advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_period_r <= pwrd_pkg::RST_SHORT_PERIOD;
      long_period_r  <= pwrd_pkg::RST_LONG_PERIOD;
      tolerance_r    <= pwrd_pkg::RST_TOLERANCE;
      target_bits_r  <= pwrd_pkg::RST_TARGET_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwrd_pkg::REG_SHORT_PERIOD: begin
          short_period_r <= cfg_wdata[pwrd_pkg::SHORT_W-1:0];
        end
        pwrd_pkg::REG_LONG_PERIOD: begin
          long_period_r <= cfg_wdata[pwrd_pkg::LONG_W-1:0];
        end
        pwrd_pkg::REG_TOLERANCE: begin
          tolerance_r <= cfg_wdata[pwrd_pkg::TOL_W-1:0];
        end
        pwrd_pkg::REG_TARGET_BITS: begin
          target_bits_r <= cfg_wdata[pwrd_pkg::TBITS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input register: holds one beat so the source is not stalled by a
  // single waiting result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_kind_r  <= in_kind;
      in_level_r <= in_level;
      in_len_r   <= in_pulse_length;
    end
  end

  // Decode step: the window comparisons are absolute differences with strict
  // less-than and the frame end test is greater-or-equal, all done at a width that cannot overflow.
  always_comb begin
    logic [AW-1:0] d;
    logic [AW-1:0] held;
    logic [AW-1:0] s;
    logic [AW-1:0] l;
    logic [AW-1:0] t;
    logic          gap_ok;
    logic          start_ok;
    logic          frame_end;
    logic          one_ok;
    logic          zero_ok;
    logic          push;
    logic          push_val;

    d    = AW'(in_len_r);
    held = AW'(held_low_r);
    s    = AW'(short_period_r);
    l    = AW'(long_period_r);
    t    = AW'(tolerance_r);

    gap_ok    = pwrd_pkg::abs_diff(d, s * pwrd_pkg::GAP_MULT) < (t * pwrd_pkg::GAP_MULT);
    start_ok  = pwrd_pkg::abs_diff(d, s) < t;
    frame_end = d >= (s * pwrd_pkg::END_MULT + t);
    one_ok    = (pwrd_pkg::abs_diff(held, l) < (t * pwrd_pkg::LONG_MULT)) &&
                (pwrd_pkg::abs_diff(d, s) < t);
    zero_ok   = (pwrd_pkg::abs_diff(held, s) < t) &&
                (pwrd_pkg::abs_diff(d, l) < (t * pwrd_pkg::LONG_MULT));

    phase_nxt      = phase_r;
    shift_code_nxt = shift_code_r;
    bit_cnt_nxt    = bit_cnt_r;
    held_low_nxt   = held_low_r;
    prev_code_nxt  = prev_code_r;
    final_code_nxt = final_code_r;
    valid_flag_nxt = valid_flag_r;
    confirmed_nxt  = 1'b0;
    push           = 1'b0;
    push_val       = 1'b0;

    if (in_kind_r) begin
      phase_nxt      = pwrd_pkg::PH_WAIT_GAP;
      shift_code_nxt = '0;
      bit_cnt_nxt    = '0;
      held_low_nxt   = '0;
      prev_code_nxt  = '0;
      final_code_nxt = '0;
      valid_flag_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        pwrd_pkg::PH_WAIT_GAP: begin
          if (!in_level_r && gap_ok) begin
            phase_nxt = pwrd_pkg::PH_START_BIT;
          end
        end
        pwrd_pkg::PH_START_BIT: begin
          if (in_level_r && start_ok) begin
            shift_code_nxt = '0;
            bit_cnt_nxt    = '0;
            held_low_nxt   = in_len_r;
            phase_nxt      = pwrd_pkg::PH_LOW_HALF;
          end else begin
            phase_nxt = pwrd_pkg::PH_WAIT_GAP;
          end
        end
        pwrd_pkg::PH_LOW_HALF: begin
          if (!in_level_r) begin
            if (frame_end) begin
              // A frame of the right length becomes the new reference; it is
              // confirmed only if it repeats the previous one and is nonzero.
              if (bit_cnt_r == target_bits_r) begin
                if (prev_code_r == shift_code_r && prev_code_r != '0) begin
                  final_code_nxt = shift_code_r;
                  valid_flag_nxt = 1'b1;
                  confirmed_nxt  = 1'b1;
                end
                prev_code_nxt = shift_code_r;
              end
              shift_code_nxt = '0;
              bit_cnt_nxt    = '0;
              held_low_nxt   = '0;
              phase_nxt      = pwrd_pkg::PH_START_BIT;
            end else begin
              held_low_nxt = in_len_r;
              phase_nxt    = pwrd_pkg::PH_HIGH_HALF;
            end
          end else begin
            phase_nxt = pwrd_pkg::PH_WAIT_GAP;
          end
        end
        pwrd_pkg::PH_HIGH_HALF: begin
          if (in_level_r && one_ok) begin
            push      = 1'b1;
            push_val  = 1'b1;
            phase_nxt = pwrd_pkg::PH_LOW_HALF;
          end else if (in_level_r && zero_ok) begin
            push      = 1'b1;
            phase_nxt = pwrd_pkg::PH_LOW_HALF;
          end else begin
            phase_nxt = pwrd_pkg::PH_WAIT_GAP;
          end
        end
        default: begin
          phase_nxt = pwrd_pkg::PH_WAIT_GAP;
        end
      endcase

      if (push) begin
        shift_code_nxt = {shift_code_r[CODE_WIDTH-2:0], push_val};
        if (bit_cnt_r != pwrd_pkg::BITCNT_MAX) begin
          bit_cnt_nxt = bit_cnt_r + 1'b1;
        end
      end
    end
  end

  // Decoder state registers advance once per decoded beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= pwrd_pkg::PH_WAIT_GAP;
      shift_code_r <= '0;
      bit_cnt_r    <= '0;
      held_low_r   <= '0;
      prev_code_r  <= '0;
      final_code_r <= '0;
      valid_flag_r <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      shift_code_r <= shift_code_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      held_low_r   <= held_low_nxt;
      prev_code_r  <= prev_code_nxt;
      final_code_r <= final_code_nxt;
      valid_flag_r <= valid_flag_nxt;
    end
  end

  // The reported code is the low 32 bits of the confirmed code, zero-extended when the code is narrower.
  generate
    if (CODE_WIDTH >= pwrd_pkg::OUT_CODE_W) begin : g_code_trunc
      assign final_code_out = final_code_nxt[pwrd_pkg::OUT_CODE_W-1:0];
    end else begin : g_code_ext
      assign final_code_out = pwrd_pkg::OUT_CODE_W'(final_code_nxt);
    end
  endgenerate

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_confirmed_r <= confirmed_nxt;
      out_code_r      <= final_code_out;
      out_seen_r      <= valid_flag_nxt;
      out_phase_r     <= phase_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_code_confirmed = out_confirmed_r;
  assign out_confirmed_code = out_code_r;
  assign out_seen_valid     = out_seen_r;
  assign out_phase          = out_phase_r;

  // The sticky flag and the confirmed code are set together, and a
  // confirmed code is never zero.
  a_flag_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    valid_flag_r == (final_code_r != '0))
    else $error("seen flag and confirmed code disagree");

  // A confirmation beat always reports the sticky flag set.
  a_confirm_sets_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_confirmed_r) |-> out_seen_r)
    else $error("confirmation without sticky flag");

  // A confirmation only happens at a frame end, which returns to the start phase.
  a_confirm_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_confirmed_r) |-> (out_phase_r == 2'(pwrd_pkg::PH_START_BIT)))
    else $error("confirmation outside frame end");

  // The source is held off only when both stages hold a beat.
  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with room in the pipeline");

endmodule

// ===== verif/pulse_width_remote_decoder_tb.sv =====
module pulse_width_remote_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The decoder runs with its default widths: 24-bit durations, 32-bit codes.
  localparam int DUR_W       = pwrd_pkg::DEF_DURATION_WIDTH;
  localparam longint DUR_MAX = (longint'(1) << DUR_W) - 1;

  // Beat kinds and line levels on the input channel.
  localparam logic KIND_PULSE = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;
  localparam logic LVL_LOW    = 1'b0;
  localparam logic LVL_HIGH   = 1'b1;

  // No correct run comes anywhere near this many cycles, even with heavy stalls.
  localparam int CYCLE_LIMIT = 400_000;

  // One result beat as the decoder reports it.
  typedef struct packed {
    logic                            confirmed;
    logic [pwrd_pkg::OUT_CODE_W-1:0] code;
    logic                            seen;
    pwrd_pkg::phase_t                phase;
  } decode_t;

  logic                            clk             = 1'b0;
  logic                            rst_n           = 1'b0;
  logic                            in_valid        = 1'b0;
  logic                            in_ready;
  logic                            in_kind         = KIND_PULSE;
  logic                            in_level        = LVL_LOW;
  logic [DUR_W-1:0]                in_pulse_length = '0;
  logic                            out_valid;
  logic                            out_ready       = 1'b0;
  logic                            out_code_confirmed;
  logic [pwrd_pkg::OUT_CODE_W-1:0] out_confirmed_code;
  logic                            out_seen_valid;
  logic [1:0]                      out_phase;
  logic                            cfg_we          = 1'b0;
  logic [pwrd_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [pwrd_pkg::CFG_DATA_W-1:0] cfg_wdata       = '0;

  pulse_width_remote_decoder uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_level           (in_level),
    .in_pulse_length    (in_pulse_length),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_code_confirmed (out_code_confirmed),
    .out_confirmed_code (out_confirmed_code),
    .out_seen_valid     (out_seen_valid),
    .out_phase          (out_phase),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Percent of cycles in which the sender holds back a beat and in which the
  // receiver holds out_ready low.
  int send_idle_pct = 37;
  int recv_idle_pct = 76;

  int mismatches     = 0;
  int beats_sent     = 0;
  int confirm_count  = 0;
  int settings_count = 0;
  int cycle_count    = 0;

  // Decoded results still owed by the block, oldest first.
  decode_t pending_decodes[$];

  // Our own copy of the configuration registers, loaded with their reset values.
  logic [pwrd_pkg::SHORT_W-1:0] cfg_short  = pwrd_pkg::RST_SHORT_PERIOD;
  logic [pwrd_pkg::LONG_W-1:0]  cfg_long   = pwrd_pkg::RST_LONG_PERIOD;
  logic [pwrd_pkg::TOL_W-1:0]   cfg_tol    = pwrd_pkg::RST_TOLERANCE;
  logic [pwrd_pkg::TBITS_W-1:0] cfg_target = pwrd_pkg::RST_TARGET_BITS;

  // Our own copy of the decoder state.
  pwrd_pkg::phase_t                dec_phase = pwrd_pkg::PH_WAIT_GAP;
  logic [pwrd_pkg::OUT_CODE_W-1:0] dec_shift = '0;
  logic [pwrd_pkg::BITCNT_W-1:0]   dec_count = '0;
  logic [DUR_W-1:0]                dec_held  = '0;
  logic [pwrd_pkg::OUT_CODE_W-1:0] dec_prev  = '0;
  logic [pwrd_pkg::OUT_CODE_W-1:0] dec_code  = '0;
  logic                            dec_seen  = 1'b0;

  // Distance between two durations; every timing window is tested on this
  // with a strict less-than.
  function automatic longint span(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // A duration picked at random strictly inside the window around a nominal
  // value, so that it passes the decoder's strict test. A zero window gives the
  // nominal value, which then never passes.
  function automatic longint near(longint nominal, longint window);
    if (window <= 0) return nominal;
    return nominal + longint'($urandom_range(2 * window - 2)) - (window - 1);
  endfunction

  function automatic logic [pwrd_pkg::OUT_CODE_W-1:0] random_code(int nbits);
    logic [pwrd_pkg::OUT_CODE_W-1:0] code;
    code = $urandom;
    if (nbits < pwrd_pkg::OUT_CODE_W) code = code & ((32'd1 << nbits) - 1);
    return code;
  endfunction

  // Advances our copy of the decoder by one accepted beat and returns the
  // result beat that the block must produce for it.
  function automatic decode_t decode_pulse(logic kind, logic level, logic [DUR_W-1:0] len);
    decode_t res;
    longint  d, sp, lp, tl;
    logic    hit;
    d   = len;
    sp  = cfg_short;
    lp  = cfg_long;
    tl  = cfg_tol;
    hit = 1'b0;
    if (kind == KIND_CLEAR) begin
      dec_phase = pwrd_pkg::PH_WAIT_GAP;
      dec_shift = '0;
      dec_count = '0;
      dec_held  = '0;
      dec_prev  = '0;
      dec_code  = '0;
      dec_seen  = 1'b0;
    end else begin
      case (dec_phase)
        pwrd_pkg::PH_WAIT_GAP: begin
          // Only a low guard gap of about 36 short periods moves us on.
          if (level == LVL_LOW && span(d, 36 * sp) < 36 * tl) begin
            dec_phase = pwrd_pkg::PH_START_BIT;
          end
        end
        pwrd_pkg::PH_START_BIT: begin
          if (level == LVL_HIGH && span(d, sp) < tl) begin
            dec_shift = '0;
            dec_count = '0;
            dec_held  = len;
            dec_phase = pwrd_pkg::PH_LOW_HALF;
          end else begin
            dec_phase = pwrd_pkg::PH_WAIT_GAP;
          end
        end
        pwrd_pkg::PH_LOW_HALF: begin
          if (level == LVL_HIGH) begin
            dec_phase = pwrd_pkg::PH_WAIT_GAP;
          end else if (d >= 10 * sp + tl) begin
            // End of frame. Only a frame of the exact length updates the
            // previous code; a repeat of a nonzero code confirms it.
            if (dec_count == cfg_target) begin
              if (dec_prev == dec_shift && dec_prev != '0) begin
                dec_code = dec_shift;
                dec_seen = 1'b1;
                hit      = 1'b1;
              end
              dec_prev = dec_shift;
            end
            dec_shift = '0;
            dec_count = '0;
            dec_held  = '0;
            dec_phase = pwrd_pkg::PH_START_BIT;
          end else begin
            dec_held  = len;
            dec_phase = pwrd_pkg::PH_HIGH_HALF;
          end
        end
        default: begin
          if (level == LVL_HIGH && span(dec_held, lp) < 2 * tl && span(d, sp) < tl) begin
            dec_shift = {dec_shift[pwrd_pkg::OUT_CODE_W-2:0], 1'b1};
            if (dec_count != '1) dec_count++;
            dec_phase = pwrd_pkg::PH_LOW_HALF;
          end else if (level == LVL_HIGH && span(dec_held, sp) < tl &&
                       span(d, lp) < 2 * tl) begin
            dec_shift = {dec_shift[pwrd_pkg::OUT_CODE_W-2:0], 1'b0};
            if (dec_count != '1) dec_count++;
            dec_phase = pwrd_pkg::PH_LOW_HALF;
          end else begin
            // Wrong level or no pattern: back to waiting, the bits stay put.
            dec_phase = pwrd_pkg::PH_WAIT_GAP;
          end
        end
      endcase
    end
    if (hit) confirm_count++;
    res.confirmed = hit;
    res.code      = dec_code;
    res.seen      = dec_seen;
    res.phase     = dec_phase;
    return res;
  endfunction

  // Presents one beat and holds it until the block takes it. The duration is
  // clamped to the field range first, as the demodulator would saturate it.
  // The caller is always just past a rising edge. An idle gap lowers valid in
  // the step of the previous acceptance; otherwise valid simply stays high.
  task automatic send_beat(logic kind, logic level, longint length);
    logic [DUR_W-1:0] len;
    decode_t          owed;
    len = (length < 0) ? '0 : (length > DUR_MAX) ? DUR_W'(DUR_MAX) : DUR_W'(length);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_level        <= level;
    in_pulse_length <= len;
    do @(posedge clk); while (!in_ready);
    owed = decode_pulse(kind, level, len);
    pending_decodes = {pending_decodes, owed};
    beats_sent++;
  endtask

  // A pulse beat with no regard for the frame structure.
  task automatic send_noise();
    longint sp, tl;
    sp = cfg_short;
    tl = cfg_tol;
    case ($urandom_range(3))
      0: send_beat(KIND_PULSE, 1'($urandom_range(1)), $urandom_range(0, 24'hFF_FFFF));
      1: send_beat(KIND_PULSE, 1'($urandom_range(1)), $urandom_range(15));
      2: send_beat(KIND_PULSE, 1'($urandom_range(1)), near(36 * sp, 36 * tl + tl));
      default: send_beat(KIND_PULSE, 1'($urandom_range(1)), near(longint'(cfg_long), 3 * tl + 1));
    endcase
  endtask

  // Stops sending and waits until every owed result has come back, then lets
  // the two pipeline stages settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [pwrd_pkg::CFG_IDX_W-1:0] idx,
                           logic [pwrd_pkg::CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      pwrd_pkg::REG_SHORT_PERIOD: cfg_short  = value[pwrd_pkg::SHORT_W-1:0];
      pwrd_pkg::REG_LONG_PERIOD:  cfg_long   = value[pwrd_pkg::LONG_W-1:0];
      pwrd_pkg::REG_TOLERANCE:    cfg_tol    = value[pwrd_pkg::TOL_W-1:0];
      default:                    cfg_target = value[pwrd_pkg::TBITS_W-1:0];
    endcase
  endtask

  // The block is only reconfigured with nothing in flight.
  task automatic apply_settings(longint sp, longint lp, longint tl, longint tb);
    wait_idle();
    write_reg(pwrd_pkg::REG_SHORT_PERIOD, pwrd_pkg::CFG_DATA_W'(sp));
    write_reg(pwrd_pkg::REG_LONG_PERIOD,  pwrd_pkg::CFG_DATA_W'(lp));
    write_reg(pwrd_pkg::REG_TOLERANCE,    pwrd_pkg::CFG_DATA_W'(tl));
    write_reg(pwrd_pkg::REG_TARGET_BITS,  pwrd_pkg::CFG_DATA_W'(tb));
    settings_count++;
  endtask

  // Sends guard gaps until the decoder waits for a start pulse. A gap can fail
  // when the tolerance is zero, so the attempts are bounded.
  task automatic send_sync();
    int tries;
    tries = 0;
    while (dec_phase != pwrd_pkg::PH_START_BIT && tries < 3) begin
      send_beat(KIND_PULSE, LVL_LOW, near(36 * longint'(cfg_short), 36 * longint'(cfg_tol)));
      tries++;
    end
  endtask

  task automatic frame_pulse(logic corrupt, logic level, longint length);
    if (corrupt) send_noise();
    else send_beat(KIND_PULSE, level, length);
  endtask

  // One frame: start pulse, a low/high pair per bit (most significant first)
  // and the closing low gap. Bits beyond the code width are random. The pulse
  // at slot corrupt_at, if any, is replaced by noise.
  task automatic send_frame(logic [pwrd_pkg::OUT_CODE_W-1:0] code, int nbits, int corrupt_at);
    longint sp, lp, tl;
    int     slot;
    logic   b;
    sp   = cfg_short;
    lp   = cfg_long;
    tl   = cfg_tol;
    slot = 0;
    frame_pulse(slot == corrupt_at, LVL_HIGH, near(sp, tl));
    slot++;
    for (int i = nbits - 1; i >= 0; i--) begin
      if (i < pwrd_pkg::OUT_CODE_W) b = code[i];
      else b = 1'($urandom_range(1));
      frame_pulse(slot == corrupt_at, LVL_LOW, b ? near(lp, 2 * tl) : near(sp, tl));
      slot++;
      frame_pulse(slot == corrupt_at, LVL_HIGH, b ? near(sp, tl) : near(lp, 2 * tl));
      slot++;
    end
    frame_pulse(slot == corrupt_at, LVL_LOW, 10 * sp + tl + $urandom_range(sp));
  endtask

  // Single pulses at the default settings: the window edges of the gap and the
  // start pulse, a wrong level in every phase, both bit patterns, a pair that
  // matches neither, a frame end with the wrong bit count, the field extremes
  // and clears that carry arbitrary level and duration.
  task automatic test_pulse_rules();
    longint sp, lp, tl;
    sp = cfg_short;
    lp = cfg_long;
    tl = cfg_tol;
    send_beat(KIND_CLEAR, LVL_HIGH, DUR_MAX);
    send_beat(KIND_PULSE, LVL_HIGH, DUR_MAX);
    send_beat(KIND_PULSE, LVL_LOW, 0);
    send_beat(KIND_PULSE, LVL_LOW, 36 * sp + 36 * tl);
    send_beat(KIND_PULSE, LVL_LOW, 36 * sp + 36 * tl - 1);
    send_beat(KIND_PULSE, LVL_LOW, sp);
    send_beat(KIND_PULSE, LVL_LOW, 36 * sp - 36 * tl + 1);
    send_beat(KIND_PULSE, LVL_HIGH, sp + tl);
    send_beat(KIND_PULSE, LVL_LOW, 36 * sp);
    send_beat(KIND_PULSE, LVL_HIGH, sp - tl + 1);
    send_beat(KIND_PULSE, LVL_HIGH, sp);
    send_beat(KIND_PULSE, LVL_LOW, 36 * sp);
    send_beat(KIND_PULSE, LVL_HIGH, sp);
    send_beat(KIND_PULSE, LVL_LOW, lp + 2 * tl - 1);
    send_beat(KIND_PULSE, LVL_HIGH, sp);
    send_beat(KIND_PULSE, LVL_LOW, sp);
    send_beat(KIND_PULSE, LVL_HIGH, lp);
    send_beat(KIND_PULSE, LVL_LOW, sp);
    send_beat(KIND_PULSE, LVL_HIGH, sp);
    send_beat(KIND_PULSE, LVL_LOW, 36 * sp);
    send_beat(KIND_PULSE, LVL_HIGH, sp);
    send_beat(KIND_PULSE, LVL_LOW, lp);
    send_beat(KIND_PULSE, LVL_LOW, lp);
    send_beat(KIND_PULSE, LVL_LOW, 36 * sp);
    send_beat(KIND_PULSE, LVL_HIGH, sp);
    send_beat(KIND_PULSE, LVL_LOW, DUR_MAX);
    send_beat(KIND_CLEAR, LVL_LOW, 0);
  endtask

  // Confirmation rules with two-bit frames: a repeat confirms, a frame of the
  // wrong length leaves the previous code alone, an all-zero code never
  // confirms, a later code replaces the confirmed one, and a clear wipes it.
  // Then a target of zero bits, where the empty code can never confirm.
  task automatic test_frame_confirm();
    apply_settings(pwrd_pkg::RST_SHORT_PERIOD, pwrd_pkg::RST_LONG_PERIOD,
                   pwrd_pkg::RST_TOLERANCE, 2);
    send_sync();
    send_frame(2'b10, 2, -1);
    send_frame(2'b10, 2, -1);
    send_frame(1'b1, 1, -1);
    send_frame(2'b10, 2, -1);
    send_frame(2'b00, 2, -1);
    send_frame(2'b00, 2, -1);
    send_frame(2'b11, 2, -1);
    send_frame(2'b11, 2, -1);
    send_beat(KIND_CLEAR, LVL_HIGH, 0);
    apply_settings(pwrd_pkg::RST_SHORT_PERIOD, pwrd_pkg::RST_LONG_PERIOD,
                   pwrd_pkg::RST_TOLERANCE, 0);
    send_sync();
    send_frame('0, 0, -1);
    send_frame('0, 0, -1);
  endtask

  // With a one-bit target, a frame of 65 bits must leave the bit counter stuck
  // at 63. A counter that wrapped would read 1 and take the frame; normal
  // frames must still work.
  task automatic test_counter_saturation();
    logic [pwrd_pkg::OUT_CODE_W-1:0] code;
    apply_settings(pwrd_pkg::RST_SHORT_PERIOD, pwrd_pkg::RST_LONG_PERIOD,
                   pwrd_pkg::RST_TOLERANCE, 1);
    code = 32'd1;
    send_sync();
    send_frame(code, 64 + 1, -1);
    send_frame(code, 1, -1);
    send_frame(code, 1, -1);
  endtask

  // Random traffic at the current settings. Most of it is bursts of well-formed
  // frames, often repeated so that codes get confirmed; the rest is frames with
  // one pulse broken, loose noise pulses and clears.
  task automatic test_random_traffic(int quota);
    int                              stop_at, nbits, pick;
    logic [pwrd_pkg::OUT_CODE_W-1:0] code;
    stop_at = beats_sent + quota;
    while (beats_sent < stop_at) begin
      pick  = $urandom_range(99);
      nbits = ($urandom_range(4) != 0) ? int'(cfg_target) : $urandom_range(40);
      code  = random_code(nbits);
      if (pick < 65) begin
        send_sync();
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(4) == 0) code = random_code(nbits);
          send_frame(code, nbits, -1);
        end
      end else if (pick < 80) begin
        send_sync();
        send_frame(code, nbits, $urandom_range(2 * nbits + 1));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 5)) send_noise();
      end else begin
        send_beat(KIND_CLEAR, 1'($urandom_range(1)), $urandom_range(0, 24'hFF_FFFF));
      end
    end
  endtask

  task automatic report_field(string name, logic [pwrd_pkg::OUT_CODE_W-1:0] want,
                              logic [pwrd_pkg::OUT_CODE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side: every accepted result beat is checked against the oldest
  // owed result, and out_ready is redrawn every cycle.
  always @(posedge clk) begin : result_check
    decode_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_decodes.size() == 0) begin
          $display("%0t: result beat with nothing expected, code %0h phase %0d",
                   $time, out_confirmed_code, out_phase);
          mismatches++;
        end else begin
          want = pending_decodes.pop_front();
          report_field("code_confirmed", want.confirmed, out_code_confirmed);
          report_field("confirmed_code", want.code, out_confirmed_code);
          report_field("seen_valid", want.seen, out_seen_valid);
          report_field("phase", want.phase, out_phase);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results owed",
               cycle_count, pending_decodes.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    // Reset is held once, at the start of the run.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // First pattern: the sender idles now and then, the receiver mostly.
    test_pulse_rules();
    test_frame_confirm();
    test_counter_saturation();
    apply_settings(pwrd_pkg::RST_SHORT_PERIOD, pwrd_pkg::RST_LONG_PERIOD,
                   pwrd_pkg::RST_TOLERANCE, pwrd_pkg::RST_TARGET_BITS);
    test_random_traffic(40);

    // Second pattern: the roles swap, and the period and tolerance registers go to their extremes.
    send_idle_pct = 76;
    recv_idle_pct = 37;
    apply_settings(4095, 8191, 4095, 32);
    test_random_traffic(10);
    apply_settings(1, 1, 0, 1);
    test_random_traffic(10);
    apply_settings(1, 1, 1, 1);
    test_random_traffic(10);

    // Third pattern: no idling on either side, with a random mid-range setting.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    begin : mid_settings
      longint sp;
      sp = $urandom_range(100, 1000);
      apply_settings(sp, sp * $urandom_range(2, 4), $urandom_range(1, sp / 3),
                     $urandom_range(1, 32));
    end
    test_random_traffic(40);

    wait_idle();
    $display("Sent %0d beats under %0d register settings and three idle patterns;",
             beats_sent, settings_count);
    $display("%0d codes were confirmed along the way.", confirm_count);
    if (mismatches == 0 && pending_decodes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pwrd_pkg.sv
hdl/pulse_width_remote_decoder.sv
verif/pulse_width_remote_decoder_tb.sv
